[rtl/fst_pkg.sv]
// Package: shared widths, command codes, sine constants and datapath control types.
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

   // Default build parameters
   localparam int DEF_SAMPLE_RATE_HZ = 16000;
   localparam int DEF_PHASE_BITS     = 24;
   localparam int DEF_SINE_DEPTH     = 1024;

   // Field widths
   localparam int CMD_W    = 1;
   localparam int STEP_W   = 24;
   localparam int LEVEL_W  = 15;
   localparam int MS_W     = 16;
   localparam int SAMPLE_W = 16;

   // Sample counters saturate at 2^21-1
   localparam int                 COUNT_W   = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Milliseconds per second, and the remainder width of that divide
   localparam int MS_PER_S = 1000;
   localparam int MSR_W    = $clog2(MS_PER_S);

   // Scaling datapath widths
   localparam int MAG_W = 15;                   // |sine| never exceeds 32767
   localparam int P1_W  = COUNT_W + LEVEL_W;    // envelope numerator * level
   localparam int P2_W  = P1_W + MAG_W;         // ... * |sine|
   localparam int DEN_W = COUNT_W + LEVEL_W;    // envelope denominator * 32767
   localparam int QUO_W = 16;                   // quotient never exceeds 32767

   // Q15 full scale and pi/2 in Q30
   localparam longint Q15_FULL    = 64'sd32767;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_START = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 1'b1;

   // Request to the multiply/divide unit
   typedef struct packed {
      logic                       start;
      logic [COUNT_W-1:0]         num;
      logic [COUNT_W-1:0]         den;
      logic [LEVEL_W-1:0]         level;
      logic signed [SAMPLE_W-1:0] sine;
   } mac_ctrl_type;

   // Status from the multiply/divide unit
   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] result;
   } mac_stat_type;

endpackage

`default_nettype wire

[rtl/fst_if.sv]
// Interfaces: request and response channels of the tone generator.
`timescale 1ns / 1ps
`default_nettype none

interface fst_req_if import fst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [STEP_W-1:0]  phase_increment;
   logic [LEVEL_W-1:0] amplitude;
   logic [MS_W-1:0]    length_ms;
   logic [MS_W-1:0]    ramp_ms;

   modport source (
      output valid, cmd, phase_increment, amplitude, length_ms, ramp_ms,
      input  ready
   );
   modport sink (
      input  valid, cmd, phase_increment, amplitude, length_ms, ramp_ms,
      output ready
   );
endinterface

interface fst_rsp_if import fst_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       in_tone;
   logic                       last;

   modport source (
      output valid, sample, in_tone, last,
      input  ready
   );
   modport sink (
      input  valid, sample, in_tone, last,
      output ready
   );
endinterface

`default_nettype wire

[rtl/fst_ms_conv.sv]
// Milliseconds to samples: constant multiply, then bit-serial divide by 1000.
`timescale 1ns / 1ps
`default_nettype none

module fst_ms_conv import fst_pkg::*; #(
   parameter int SAMPLE_RATE_HZ = DEF_SAMPLE_RATE_HZ
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [MS_W-1:0]    ms,
   output logic                    done,
   output logic [COUNT_W-1:0]      samples
);

   localparam int RATE_W = $clog2(SAMPLE_RATE_HZ + 1);
   localparam int PROD_W = MS_W + RATE_W;
   localparam int CNT_W  = $clog2(PROD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [MSR_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;

   logic [MSR_W:0]    trial;
   logic              ge;

   // One quotient bit per cycle, dividend shifted out MSB first
   assign trial = {rem_ff, dvd_ff[PROD_W-1]};
   assign ge    = trial >= (MSR_W + 1)'(MS_PER_S);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PROD_W - 1);
         dvd_in  = PROD_W'(ms) * PROD_W'(SAMPLE_RATE_HZ);
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? MSR_W'(trial - (MSR_W + 1)'(MS_PER_S)) : trial[MSR_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], ge};
         dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Saturate to the counter range
   assign done    = done_ff;
   assign samples = (quo_ff > PROD_W'(COUNT_MAX)) ? COUNT_MAX : quo_ff[COUNT_W-1:0];

endmodule

`default_nettype wire

[rtl/fst_sine_rom.sv]
// Sine table: SINE_DEPTH Q15 entries built at elaboration, registered read.
`timescale 1ns / 1ps
`default_nettype none

module fst_sine_rom import fst_pkg::*; #(
   parameter int SINE_DEPTH = DEF_SINE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic [$clog2(SINE_DEPTH)-1:0] addr,
   output logic signed [SAMPLE_W-1:0]         data
);

   logic signed [SAMPLE_W-1:0] rom [SINE_DEPTH];
   logic signed [SAMPLE_W-1:0] data_ff;

   // Entry k = sin(2*pi*k/depth) via quarter-wave symmetry
   for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_entry
      localparam int     M    = 4 * k;
      localparam int     QUAD = M / SINE_DEPTH;
      localparam int     REM  = M % SINE_DEPTH;
      localparam int     ARG  = (QUAD == 1 || QUAD == 3) ? SINE_DEPTH - REM : REM;
      localparam longint X    = (longint'(ARG) * HALF_PI_Q30) / SINE_DEPTH;
      // Taylor series in Q30 up to x^15; term n divides by (2n)(2n+1)
      localparam longint X2   = (X * X) >> 30;
      localparam longint T1   = ((X  * X2) >> 30) / 6;
      localparam longint T2   = ((T1 * X2) >> 30) / 20;
      localparam longint T3   = ((T2 * X2) >> 30) / 42;
      localparam longint T4   = ((T3 * X2) >> 30) / 72;
      localparam longint T5   = ((T4 * X2) >> 30) / 110;
      localparam longint T6   = ((T5 * X2) >> 30) / 156;
      localparam longint T7   = ((T6 * X2) >> 30) / 210;
      localparam longint SUM  = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
      localparam longint POS  = (SUM < 0) ? 64'sd0 : SUM;
      // Round Q30 to Q15 scale, half up, clamp at full scale
      localparam longint Q    = (POS * Q15_FULL + (longint'(1) << 29)) >> 30;
      localparam logic signed [SAMPLE_W-1:0] MAG =
         SAMPLE_W'((Q > Q15_FULL) ? Q15_FULL : Q);
      assign rom[k] = (QUAD >= 2) ? -MAG : MAG;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[addr];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[rtl/fst_mul_div.sv]
// Bit-serial scaling unit: num * level * sine / (den * 32767), truncated to zero.
`timescale 1ns / 1ps
`default_nettype none

module fst_mul_div import fst_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mac_ctrl_type ctrl,
   output mac_stat_type      stat
);

   localparam int CNT_W = $clog2(QUO_W);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL_A,
      PH_MUL_B,
      PH_DIV
   } phase_type;

   phase_type                  ph_ff, ph_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [P2_W-1:0]            acc_ff, acc_in;
   logic [P2_W-1:0]            mcand_ff, mcand_in;
   logic [LEVEL_W-1:0]         mplier_ff, mplier_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [DEN_W-1:0]           dsr_ff, dsr_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]           dlo_ff, dlo_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic                       done_ff, done_in;
   logic signed [SAMPLE_W-1:0] result_ff, result_in;

   logic [P2_W-1:0]            sum;
   logic [DEN_W:0]             trial;
   logic                       ge;
   logic [QUO_W-1:0]           quo_next;
   logic [SAMPLE_W-1:0]        sine_abs;

   // Shift-add partial product and restoring divide step
   assign sum      = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign trial    = {rem_ff, dlo_ff[QUO_W-1]};
   assign ge       = trial >= {1'b0, dsr_ff};
   assign quo_next = {quo_ff[QUO_W-2:0], ge};
   assign sine_abs = ctrl.sine[SAMPLE_W-1] ? SAMPLE_W'(-ctrl.sine) : SAMPLE_W'(ctrl.sine);

   always_comb begin
      ph_in     = ph_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      dlo_in    = dlo_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (ph_ff)
         PH_IDLE: begin
            if (ctrl.start) begin
               ph_in     = PH_MUL_A;
               cnt_in    = CNT_W'(LEVEL_W - 1);
               acc_in    = '0;
               mcand_in  = P2_W'(ctrl.num);
               mplier_in = ctrl.level;
               mag_in    = sine_abs[MAG_W-1:0];
               neg_in    = ctrl.sine[SAMPLE_W-1];
               // den * 32767 as (den << 15) - den
               dsr_in    = (DEN_W'(ctrl.den) << LEVEL_W) - DEN_W'(ctrl.den);
            end
         end
         PH_MUL_A: begin
            acc_in    = sum;
            mcand_in  = {mcand_ff[P2_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[LEVEL_W-1:1]};
            if (cnt_ff == '0) begin
               // second product: (num * level) * |sine|
               ph_in     = PH_MUL_B;
               cnt_in    = CNT_W'(MAG_W - 1);
               acc_in    = '0;
               mcand_in  = sum;
               mplier_in = LEVEL_W'(mag_ff);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         PH_MUL_B: begin
            acc_in    = sum;
            mcand_in  = {mcand_ff[P2_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[LEVEL_W-1:1]};
            if (cnt_ff == '0) begin
               // quotient fits 16 bits, so the top bits start as remainder
               ph_in  = PH_DIV;
               cnt_in = CNT_W'(QUO_W - 1);
               rem_in = DEN_W'(sum[P2_W-1:QUO_W]);
               dlo_in = sum[QUO_W-1:0];
               quo_in = '0;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         PH_DIV: begin
            rem_in = ge ? DEN_W'(trial - {1'b0, dsr_ff}) : trial[DEN_W-1:0];
            dlo_in = {dlo_ff[QUO_W-2:0], 1'b0};
            quo_in = quo_next;
            if (cnt_ff == '0) begin
               ph_in     = PH_IDLE;
               done_in   = 1'b1;
               result_in = neg_ff ? SAMPLE_W'(QUO_W'(0) - quo_next) : SAMPLE_W'(quo_next);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      dsr_ff    <= dsr_in;
      rem_ff    <= rem_in;
      dlo_ff    <= dlo_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = result_ff;

endmodule

`default_nettype wire

[rtl/faded_sine_tone_generator_top.sv]
// Top level: faded sine tone generator control, phase and envelope state.
//
// Usage: requests arrive on req_bus (valid/ready). cmd START loads phase
// increment, amplitude, tone length and fade length and returns no response;
// cmd TICK returns one response on rsp_bus with a PCM sample, in_tone and last.
// A tick with no active tone returns a silent response.
// A start occupies the block while both converters run their serial divide by
// 1000 (30 steps at the default rate, one per product bit of
// 16 + clog2(SAMPLE_RATE_HZ+1)), then it loads the counts. An active tick
// responds after a table lookup, then the bit-serial scaling unit (15 + 15
// multiply steps and 16 divide steps); the block frees for the next request
// when the response is loaded. A silent tick skips the lookup and scaling unit.
// One request is worked on at a time; req_bus.ready is high only when the
// block is free to take the next request.
// The response sits in an output register, so a new request is taken while
// the previous response waits; a tick that finishes while the receiver still
// stalls holds its result until the output register frees.
// Reset (synchronous, active high) clears the tone, leaving no tone active,
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module faded_sine_tone_generator_top import fst_pkg::*; #(
   parameter int SAMPLE_RATE_HZ = DEF_SAMPLE_RATE_HZ,
   parameter int PHASE_BITS     = DEF_PHASE_BITS,
   parameter int SINE_DEPTH     = DEF_SINE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   fst_req_if.sink   req_bus,
   fst_rsp_if.source rsp_bus
);

   localparam int ADDR_W  = $clog2(SINE_DEPTH);
   localparam int DEPTH_W = $clog2(SINE_DEPTH + 1);
   localparam int IDXP_W  = PHASE_BITS + DEPTH_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LOOK,
      ST_MAC_GO,
      ST_MAC,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic                       tone_active_ff, tone_active_in;
   logic [COUNT_W-1:0]         sample_index_ff, sample_index_in;
   logic [COUNT_W-1:0]         tone_samples_ff, tone_samples_in;
   logic [COUNT_W-1:0]         ramp_samples_ff, ramp_samples_in;
   logic [PHASE_BITS-1:0]      phase_accum_ff, phase_accum_in;
   logic [STEP_W-1:0]          phase_step_ff, phase_step_in;
   logic [LEVEL_W-1:0]         level_ff, level_in;
   logic [COUNT_W-1:0]         num_ff, num_in;
   logic [COUNT_W-1:0]         den_ff, den_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic                       res_tone_ff, res_tone_in;
   logic                       res_last_ff, res_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_in_tone_ff, rsp_in_tone_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_fire;
   logic                       conv_start;
   logic                       len_done, ramp_done;
   logic [COUNT_W-1:0]         len_samples, ramp_samples;
   logic signed [SAMPLE_W-1:0] sine_q;
   mac_ctrl_type               mac_ctrl;
   mac_stat_type               mac_stat;

   logic [COUNT_W-1:0]         env_num, env_den;
   logic                       tick_last;
   logic [IDXP_W-1:0]          idx_prod;

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign conv_start = req_fire && (req_bus.cmd == CMD_START);

   // ms to sample count, tone length and fade length in parallel
   fst_ms_conv #(.SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)) u_len_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (conv_start),
      .ms      (req_bus.length_ms),
      .done    (len_done),
      .samples (len_samples)
   );

   fst_ms_conv #(.SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)) u_ramp_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (conv_start),
      .ms      (req_bus.ramp_ms),
      .done    (ramp_done),
      .samples (ramp_samples)
   );

   fst_sine_rom #(.SINE_DEPTH(SINE_DEPTH)) u_sine_rom (
      .clock (clock),
      .addr  (idx_ff),
      .data  (sine_q)
   );

   assign mac_ctrl.start = (state_ff == ST_MAC_GO);
   assign mac_ctrl.num   = num_ff;
   assign mac_ctrl.den   = den_ff;
   assign mac_ctrl.level = level_ff;
   assign mac_ctrl.sine  = sine_q;

   fst_mul_div u_mul_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .stat  (mac_stat)
   );

   // Envelope: fade-in, else fade-out when the fade fits the tone, else flat
   always_comb begin
      env_num = COUNT_W'(1);
      env_den = COUNT_W'(1);
      if ((ramp_samples_ff != '0) && (sample_index_ff < ramp_samples_ff)) begin
         env_num = sample_index_ff;
         env_den = ramp_samples_ff;
      end else if ((ramp_samples_ff != '0) && (ramp_samples_ff <= tone_samples_ff) &&
                   (sample_index_ff >= tone_samples_ff - ramp_samples_ff)) begin
         env_num = tone_samples_ff - sample_index_ff;
         env_den = ramp_samples_ff;
      end
   end

   assign tick_last = ((COUNT_W + 1)'(sample_index_ff) + (COUNT_W + 1)'(1)) >=
                      (COUNT_W + 1)'(tone_samples_ff);

   // Table index = phase * depth >> PHASE_BITS
   assign idx_prod = IDXP_W'(phase_accum_ff) * IDXP_W'(SINE_DEPTH);

   // Control sequencer
   always_comb begin
      state_in        = state_ff;
      tone_active_in  = tone_active_ff;
      sample_index_in = sample_index_ff;
      tone_samples_in = tone_samples_ff;
      ramp_samples_in = ramp_samples_ff;
      phase_accum_in  = phase_accum_ff;
      phase_step_in   = phase_step_ff;
      level_in        = level_ff;
      num_in          = num_ff;
      den_in          = den_ff;
      idx_in          = idx_ff;
      res_tone_in     = res_tone_ff;
      res_last_in     = res_last_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_in_tone_in  = rsp_in_tone_ff;
      rsp_last_in     = rsp_last_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.cmd == CMD_START) begin
                  phase_step_in   = req_bus.phase_increment;
                  level_in        = req_bus.amplitude;
                  sample_index_in = '0;
                  phase_accum_in  = '0;
                  tone_active_in  = 1'b0;
                  state_in        = ST_CONV;
               end else if (!tone_active_ff) begin
                  res_tone_in = 1'b0;
                  res_last_in = 1'b0;
                  state_in    = ST_DONE;
               end else begin
                  num_in          = env_num;
                  den_in          = env_den;
                  idx_in          = idx_prod[PHASE_BITS +: ADDR_W];
                  res_tone_in     = 1'b1;
                  res_last_in     = tick_last;
                  sample_index_in = sample_index_ff + COUNT_W'(1);
                  phase_accum_in  = phase_accum_ff + PHASE_BITS'(phase_step_ff);
                  if (tick_last) begin
                     tone_active_in = 1'b0;
                  end
                  state_in = ST_LOOK;
               end
            end
         end
         ST_CONV: begin
            if (len_done && ramp_done) begin
               tone_samples_in = len_samples;
               ramp_samples_in = ramp_samples;
               tone_active_in  = (len_samples != '0);
               state_in        = ST_IDLE;
            end
         end
         ST_LOOK: begin
            state_in = ST_MAC_GO;
         end
         ST_MAC_GO: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (mac_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = res_tone_ff ? mac_stat.result : '0;
               rsp_in_tone_in = res_tone_ff;
               rsp_last_in    = res_last_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tone_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tone_active_ff <= tone_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sample_index_ff <= sample_index_in;
      tone_samples_ff <= tone_samples_in;
      ramp_samples_ff <= ramp_samples_in;
      phase_accum_ff  <= phase_accum_in;
      phase_step_ff   <= phase_step_in;
      level_ff        <= level_in;
      num_ff          <= num_in;
      den_ff          <= den_in;
      idx_ff          <= idx_in;
      res_tone_ff     <= res_tone_in;
      res_last_ff     <= res_last_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_in_tone_ff  <= rsp_in_tone_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.sample  = rsp_sample_ff;
   assign rsp_bus.in_tone = rsp_in_tone_ff;
   assign rsp_bus.last    = rsp_last_ff;

`ifndef SYNTHESIS
   // An active tone always has samples left
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      tone_active_ff |-> (sample_index_ff < tone_samples_ff))
      else $error("sample index reached tone length while tone active");

   // A response outside a tone is silent and never marked last
   a_silent_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_in_tone_ff) |-> ((rsp_sample_ff == '0) && !rsp_last_ff))
      else $error("response outside tone is not silent");

   // Scaling unit finishes only while the sequencer waits for it
   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> (state_ff == ST_MAC))
      else $error("scaling unit finished outside its wait state");

   // A finished tick always ends up in the output register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("finished result not held in output register");
`endif

endmodule

`default_nettype wire
